>>> rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/fssu_pkg.sv
package fssu_pkg;

  // binary32 constants
  localparam logic [31:0] F_LOG2E    = 32'h3FB8AA3B;
  localparam logic [31:0] F_LN2      = 32'h3F317218;
  localparam logic [31:0] F_PC5      = 32'h3C088889;
  localparam logic [31:0] F_HALF     = 32'h3F000000;
  localparam logic [31:0] F_NEG_HALF = 32'hBF000000;
  localparam logic [31:0] F_ONE      = 32'h3F800000;
  localparam logic [31:0] F_EXP_HI   = 32'h42B00000;
  localparam logic [31:0] F_QNAN     = 32'h7FC00000;
  localparam logic [31:0] F_QUIET    = 32'h00400000;
  localparam logic [30:0] MAG_EXP_LO = 31'h42AE0000;

  localparam logic signed [9:0] EXP_BIAS = 10'sd127;
  localparam logic signed [9:0] EXP_MAXF = 10'sd254;

  // Horner coefficients after the leading one (PC5)
  localparam int HORNER_N = 5;
  localparam logic [31:0] HORNER_C [HORNER_N] = '{
    32'h3D2AAAAB, 32'h3E2AAAAB, F_HALF, F_ONE, F_ONE
  };

  typedef logic signed [10:0] fexp_t;

  typedef enum logic [1:0] {
    SPC_NONE,
    SPC_NAN,
    SPC_INF,
    SPC_ZERO
  } spc_e;

  // context that rides along with each element
  typedef struct packed {
    logic [31:0]       x;
    logic              last;
    logic [31:0]       arg;
    logic signed [8:0] n;
    logic              zero;
  } side_t;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  endfunction

  function automatic fexp_t eff_exp(input logic [31:0] b);
    return (b[30:23] == 8'd0) ? 11'sd1 : fexp_t'({3'b000, b[30:23]});
  endfunction

  function automatic logic [23:0] sig24(input logic [31:0] b);
    return {b[30:23] != 8'd0, b[22:0]};
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] z;
    z = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) z = 6'(47 - i);
    end
    return z;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] z;
    z = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) z = 5'(27 - i);
    end
    return z;
  endfunction

  // Round to nearest even and pack. sig[26] is the integer bit (or sig is 0),
  // sig[2] guard, sig[1] round, sig[0] sticky; ex is the biased exponent.
  function automatic logic [31:0] fp_pack(input logic sgn, input fexp_t ex,
                                          input logic [26:0] sig);
    fexp_t       e;
    logic [26:0] sh;
    logic [10:0] amt;
    logic [26:0] mask;
    logic        inc;
    logic [24:0] m;
    logic [31:0] res;
    e  = ex;
    sh = sig;
    // denormalize below the smallest normal exponent
    if (ex < 11'sd1) begin
      amt = 11'(11'sd1 - ex);
      if (amt > 11'd26) begin
        sh = {26'd0, |sig};
      end else begin
        mask = (27'd1 << amt[4:0]) - 27'd1;
        sh   = (sig >> amt[4:0]) | {26'd0, |(sig & mask)};
      end
      e = 11'sd1;
    end
    inc = sh[2] & (sh[3] | sh[1] | sh[0]);
    m   = {1'b0, sh[26:3]} + {24'd0, inc};
    if (m[24]) begin
      m = m >> 1;
      e = e + 11'sd1;
    end
    if (sig == 27'd0) begin
      res = {sgn, 31'd0};
    end else if (e > 11'sd254) begin
      res = {sgn, 8'hFF, 23'd0};
    end else begin
      res = {sgn, m[23] ? e[7:0] : 8'h00, m[22:0]};
    end
    return res;
  endfunction

endpackage

>>> rtl/core/float32_sigmoid_silu_unit_top.sv
// Streaming sigmoid / SiLU on IEEE binary32 values: one element enters per
// clock while the output is not stalled, and its result is presented on the
// output in order, with last_out_o a copy of last_in_i. The rate is one
// element per cycle when out_ready_i holds no beat back. Each element passes
// the chain of separately rounded float operations: the input register, three
// stages for each multiply and each add (fifteen of them in the exponential,
// one more add for 1+exp and the final SiLU multiply), one stage that
// truncates n, the 27-stage reciprocal that produces one quotient bit per
// stage, and the output register. The whole pipeline advances together: it
// moves whenever the output register is empty or being taken, so in_ready_o
// follows out_ready_i in the same cycle. cfg_wdata_i selects sigmoid (0) or
// SiLU (1) and is written with cfg_we_i while no element is in flight.
module float32_sigmoid_silu_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_bits_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] y_bits_o,
  output logic        last_out_o
);
  import fssu_pkg::*;

  logic        adv;
  logic        mode_q;
  logic        v0_q;
  logic [31:0] x0_q;
  logic        last0_q;
  logic [31:0] neg, c0;
  logic        nan0, zero0;
  side_t       side0;

  logic        t_v, s_v, m_v, f_v, ex_v, den_v, sig_v, y_v;
  logic [31:0] t_r, s_r, m_r, f_r, ex_r, den_r, sig_r, y_r;
  side_t       t_s, s_s, m_s, f_s, ex_s, den_s, sig_s, y_s;
  logic [31:0] half;

  logic [7:0]  cv_e, cv_mag;
  logic [23:0] cv_sh;
  logic signed [8:0] n_d;
  side_t       cv_d;
  logic        cv_v_q;
  side_t       cv_q;

  logic [7:0]  nf_mag;
  logic [2:0]  nf_k;
  logic [30:0] nf_w;
  logic [31:0] nf;

  logic [HORNER_N:0] hv;
  logic [31:0] hp [HORNER_N+1];
  side_t       hs [HORNER_N+1];

  logic signed [9:0] be;
  logic [31:0] scale;
  side_t       ys_d;

  logic        out_valid_q, last_q;
  logic [31:0] y_q, y_d;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q    <= x_bits_i;
      last0_q <= last_in_i;
    end
  end

  // negate and clamp the exponential argument
  always_comb begin
    nan0  = is_nan(x0_q);
    neg   = (x0_q[30:0] == 31'd0) ? 32'd0 : {~x0_q[31], x0_q[30:0]};
    zero0 = !nan0 && neg[31] && (neg[30:0] > MAG_EXP_LO);
    if (zero0) begin
      c0 = 32'd0;
    end else if (!nan0 && (neg[31] || (neg[30:0] < F_EXP_HI[30:0]))) begin
      c0 = neg;
    end else begin
      c0 = F_EXP_HI;
    end
    side0 = '{x: x0_q, last: last0_q, arg: c0, n: 9'sd0, zero: zero0};
  end

  // t = c * log2e
  fssu_fmul u_mul_t (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v0_q), .a_i(c0), .b_i(F_LOG2E),
    .side_i(side0), .valid_o(t_v), .r_o(t_r), .side_o(t_s)
  );

  assign half = t_r[31] ? F_NEG_HALF : F_HALF;

  // s = t +/- 0.5
  fssu_fadd u_add_s (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(t_v), .a_i(t_r), .b_i(half),
    .side_i(t_s), .valid_o(s_v), .r_o(s_r), .side_o(s_s)
  );

  // truncate s toward zero
  always_comb begin
    cv_e  = s_r[30:23];
    cv_sh = sig24(s_r) >> (8'd150 - cv_e);
    cv_mag = (cv_e < 8'd127) ? 8'd0 : cv_sh[7:0];
    n_d   = s_r[31] ? -$signed({1'b0, cv_mag}) : $signed({1'b0, cv_mag});
    cv_d  = s_s;
    cv_d.n = n_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_v_q <= 1'b0;
    end else if (adv) begin
      cv_v_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) cv_q <= cv_d;
  end

  // n back to float, exact
  always_comb begin
    nf_mag = cv_q.n[8] ? 8'(-cv_q.n) : cv_q.n[7:0];
    nf_k   = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (nf_mag[i]) nf_k = 3'(i);
    end
    nf_w = {nf_mag, 23'd0} >> nf_k;
    nf   = (nf_mag == 8'd0) ? 32'd0 :
           {cv_q.n[8], 8'(8'd127 + {5'd0, nf_k}), nf_w[22:0]};
  end

  // m = nf * ln2
  fssu_fmul u_mul_m (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(cv_v_q), .a_i(nf), .b_i(F_LN2),
    .side_i(cv_q), .valid_o(m_v), .r_o(m_r), .side_o(m_s)
  );

  // f = c - m
  fssu_fadd u_add_f (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(m_v), .a_i(m_s.arg),
    .b_i({~m_r[31], m_r[30:0]}), .side_i(m_s), .valid_o(f_v), .r_o(f_r),
    .side_o(f_s)
  );

  // Horner chain, f rides in the context
  always_comb begin
    hs[0]     = f_s;
    hs[0].arg = f_r;
  end
  assign hv[0] = f_v;
  assign hp[0] = F_PC5;

  for (genvar k = 0; k < HORNER_N; k++) begin : g_horner
    logic        q_v;
    logic [31:0] q_r;
    side_t       q_s;

    fssu_fmul u_mul_q (
      .clk_i, .rst_ni, .en_i(adv), .valid_i(hv[k]), .a_i(hs[k].arg), .b_i(hp[k]),
      .side_i(hs[k]), .valid_o(q_v), .r_o(q_r), .side_o(q_s)
    );

    fssu_fadd u_add_p (
      .clk_i, .rst_ni, .en_i(adv), .valid_i(q_v), .a_i(HORNER_C[k]), .b_i(q_r),
      .side_i(q_s), .valid_o(hv[k+1]), .r_o(hp[k+1]), .side_o(hs[k+1])
    );
  end

  // scale = 2^min(n,127) (biased field min(n+127,254)), zero when the field is not positive or the zero flag is set
  always_comb begin
    be = {hs[HORNER_N].n[8], hs[HORNER_N].n} + EXP_BIAS;
    if (be > EXP_MAXF) be = EXP_MAXF;
    scale = (be > 10'sd0 && !hs[HORNER_N].zero) ? {1'b0, be[7:0], 23'd0} : 32'd0;
  end

  // exp = p * scale
  fssu_fmul u_mul_ex (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(hv[HORNER_N]), .a_i(hp[HORNER_N]),
    .b_i(scale), .side_i(hs[HORNER_N]), .valid_o(ex_v), .r_o(ex_r), .side_o(ex_s)
  );

  // den = 1 + exp
  fssu_fadd u_add_den (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(ex_v), .a_i(F_ONE), .b_i(ex_r),
    .side_i(ex_s), .valid_o(den_v), .r_o(den_r), .side_o(den_s)
  );

  // sig = 1 / den
  fssu_recip u_recip (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(den_v), .den_i(den_r),
    .side_i(den_s), .valid_o(sig_v), .r_o(sig_r), .side_o(sig_s)
  );

  always_comb begin
    ys_d     = sig_s;
    ys_d.arg = sig_r;
  end

  // y = x * sig
  fssu_fmul u_mul_y (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(sig_v), .a_i(sig_s.x), .b_i(sig_r),
    .side_i(ys_d), .valid_o(y_v), .r_o(y_r), .side_o(y_s)
  );

  // pick the result by mode; a NaN input in SiLU mode comes back quiet
  always_comb begin
    if (!mode_q) begin
      y_d = y_s.arg;
    end else if (is_nan(y_s.x)) begin
      y_d = y_s.x | F_QUIET;
    end else begin
      y_d = y_r;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= y_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q    <= y_d;
      last_q <= y_s.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign y_bits_o    = y_q;
  assign last_out_o  = last_q;

endmodule

>>> rtl/core/fssu_fmul.sv
module fssu_fmul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     a_i,
  input  logic [31:0]     b_i,
  input  fssu_pkg::side_t side_i,
  output logic            valid_o,
  output logic [31:0]     r_o,
  output fssu_pkg::side_t side_o
);
  import fssu_pkg::*;

  logic        v1_q, v2_q, v3_q;
  spc_e        spc1_d, spc1_q, spc2_q;
  logic        sgn1_q, sgn2_q;
  fexp_t       ex1_q, ex2_q;
  logic [47:0] p1_q, p2_q;
  side_t       side1_q, side2_q, side3_q;
  logic [31:0] r_q;
  logic [5:0]  lz;
  logic        za, zb;

  // classify operands
  always_comb begin
    za = (a_i[30:0] == 31'd0);
    zb = (b_i[30:0] == 31'd0);
    if (is_nan(a_i) || is_nan(b_i) || (is_inf(a_i) && zb) || (is_inf(b_i) && za)) begin
      spc1_d = SPC_NAN;
    end else if (is_inf(a_i) || is_inf(b_i)) begin
      spc1_d = SPC_INF;
    end else if (za || zb) begin
      spc1_d = SPC_ZERO;
    end else begin
      spc1_d = SPC_NONE;
    end
  end

  assign lz = lzc48(p1_q);

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // multiply, normalize, round
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spc1_q  <= spc1_d;
      sgn1_q  <= a_i[31] ^ b_i[31];
      ex1_q   <= eff_exp(a_i) + eff_exp(b_i) - 11'sd126;
      p1_q    <= sig24(a_i) * sig24(b_i);
      side1_q <= side_i;

      spc2_q  <= spc1_q;
      sgn2_q  <= sgn1_q;
      ex2_q   <= ex1_q - fexp_t'({5'd0, lz});
      p2_q    <= p1_q << lz;
      side2_q <= side1_q;

      side3_q <= side2_q;
      case (spc2_q)
        SPC_NAN:  r_q <= F_QNAN;
        SPC_INF:  r_q <= {sgn2_q, 8'hFF, 23'd0};
        SPC_ZERO: r_q <= {sgn2_q, 31'd0};
        default:  r_q <= fp_pack(sgn2_q, ex2_q, {p2_q[47:22], |p2_q[21:0]});
      endcase
    end
  end

  assign valid_o = v3_q;
  assign r_o     = r_q;
  assign side_o  = side3_q;

endmodule

>>> rtl/core/fssu_fadd.sv
module fssu_fadd (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     a_i,
  input  logic [31:0]     b_i,
  input  fssu_pkg::side_t side_i,
  output logic            valid_o,
  output logic [31:0]     r_o,
  output fssu_pkg::side_t side_o
);
  import fssu_pkg::*;

  logic        v1_q, v2_q, v3_q;
  logic [31:0] big, lit;
  fexp_t       dd;
  logic [26:0] mb0, mb_d, mask;
  spc_e        spc1_d, spc1_q, spc2_q;
  logic        sgn1_q, sgn2_q, sub1_q, sub2_q;
  fexp_t       ex1_q, ex2_q;
  logic [26:0] ma1_q, mb1_q;
  logic [27:0] sum2_q;
  side_t       side1_q, side2_q, side3_q;
  logic [31:0] r_q;
  logic [4:0]  lz;
  logic [26:0] nsig;
  fexp_t       nex;
  logic        nsgn;

  // order by magnitude and align the smaller operand
  always_comb begin
    if (b_i[30:0] > a_i[30:0]) begin
      big = b_i;
      lit = a_i;
    end else begin
      big = a_i;
      lit = b_i;
    end
    dd   = eff_exp(big) - eff_exp(lit);
    mb0  = {sig24(lit), 3'b000};
    mask = (27'd1 << dd[4:0]) - 27'd1;
    if (dd > 11'sd26) begin
      mb_d = {26'd0, |mb0};
    end else begin
      mb_d = (mb0 >> dd[4:0]) | {26'd0, |(mb0 & mask)};
    end
    if (is_nan(a_i) || is_nan(b_i) ||
        (is_inf(a_i) && is_inf(b_i) && (a_i[31] != b_i[31]))) begin
      spc1_d = SPC_NAN;
    end else if (is_inf(a_i) || is_inf(b_i)) begin
      spc1_d = SPC_INF;
    end else begin
      spc1_d = SPC_NONE;
    end
  end

  // normalize the sum
  always_comb begin
    lz   = lzc28(sum2_q);
    nsgn = (sum2_q == 28'd0 && sub2_q) ? 1'b0 : sgn2_q;
    if (sum2_q[27]) begin
      nsig = {sum2_q[27:2], sum2_q[1] | sum2_q[0]};
      nex  = ex2_q + 11'sd1;
    end else begin
      nsig = 27'(sum2_q << (lz - 5'd1));
      nex  = ex2_q - fexp_t'({6'd0, lz}) + 11'sd1;
    end
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // align, add, round
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spc1_q  <= spc1_d;
      sgn1_q  <= big[31];
      sub1_q  <= a_i[31] ^ b_i[31];
      ex1_q   <= eff_exp(big);
      ma1_q   <= {sig24(big), 3'b000};
      mb1_q   <= mb_d;
      side1_q <= side_i;

      spc2_q  <= spc1_q;
      sgn2_q  <= sgn1_q;
      sub2_q  <= sub1_q;
      ex2_q   <= ex1_q;
      sum2_q  <= sub1_q ? ({1'b0, ma1_q} - {1'b0, mb1_q}) : ({1'b0, ma1_q} + {1'b0, mb1_q});
      side2_q <= side1_q;

      side3_q <= side2_q;
      case (spc2_q)
        SPC_NAN: r_q <= F_QNAN;
        SPC_INF: r_q <= {sgn2_q, 8'hFF, 23'd0};
        default: r_q <= fp_pack(nsgn, nex, nsig);
      endcase
    end
  end

  assign valid_o = v3_q;
  assign r_o     = r_q;
  assign side_o  = side3_q;

endmodule

>>> rtl/core/fssu_recip.sv
module fssu_recip (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     den_i,
  input  fssu_pkg::side_t side_i,
  output logic            valid_o,
  output logic [31:0]     r_o,
  output fssu_pkg::side_t side_o
);
  import fssu_pkg::*;

  // one quotient bit per stage after the seeded integer bit: 23 fraction bits, guard, round
  localparam int NSTEP = 25;

  typedef struct packed {
    logic [23:0] r;
    logic [25:0] q;
    logic [23:0] d;
    fexp_t       ex;
    logic        one;
    side_t       side;
  } rstg_t;

  function automatic rstg_t div_step(input rstg_t s);
    rstg_t       o;
    logic [24:0] rr;
    logic        ge;
    o  = s;
    rr = {s.r, 1'b0};
    ge = (rr >= {1'b0, s.d});
    o.r = ge ? 24'(rr - {1'b0, s.d}) : rr[23:0];
    o.q = {s.q[24:0], ge};
    return o;
  endfunction

  rstg_t       stg_q [NSTEP+1];
  logic        v_q   [NSTEP+1];
  rstg_t       stg0_d;
  logic [31:0] r_q;
  side_t       side_q;
  logic        vo_q;
  logic [26:0] qsig;

  // seed the divider with 2.0 / significand
  always_comb begin
    stg0_d.d    = sig24(den_i);
    stg0_d.one  = (den_i[22:0] == 23'd0);
    stg0_d.ex   = (stg0_d.one ? 11'sd254 : 11'sd253) - eff_exp(den_i);
    stg0_d.r    = 24'(25'h1000000 - {1'b0, stg0_d.d});
    stg0_d.q    = 26'd1;
    stg0_d.side = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) stg_q[0] <= stg0_d;
  end

  // quotient bit stages
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) stg_q[k+1] <= div_step(stg_q[k]);
    end
  end

  // exact power of two when the significand is one
  assign qsig = stg_q[NSTEP].one ? 27'h4000000 :
                {stg_q[NSTEP].q, stg_q[NSTEP].r != 24'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q    <= fp_pack(1'b0, stg_q[NSTEP].ex, qsig);
      side_q <= stg_q[NSTEP].side;
    end
  end

  assign valid_o = vo_q;
  assign r_o     = r_q;
  assign side_o  = side_q;

endmodule

>>> rtl/core/fssu_checker.sv
`include "assert_macros.svh"

module fssu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        cfg_wdata_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] y_bits_o,
  input logic        last_out_o
);

  logic mode_q;

  // track the mode seen on the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // a stalled result beat holds
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(y_bits_o) && $stable(last_out_o))

  // input side moves exactly when the output register frees up
  `ASSERT_IMPL(a_in_ready, 1'b1, in_ready_o == (!out_valid_o || out_ready_i))

  // sigmoid results are non-negative and at most one
  `ASSERT_IMPL(a_sig_range, out_valid_o && !mode_q, y_bits_o <= 32'h3F800000)

endmodule

bind float32_sigmoid_silu_unit_top fssu_checker u_fssu_checker (.*);
